[rtl/first_fit_block_allocator_defines.svh]
// assertion macros shared by the allocator checker
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define FFBA_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk outside reset
`define FFBA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ffba_pkg.sv]
// shared types, constants and helpers of the block allocator
package ffba_pkg;

  localparam int POOL_BYTES  = 65536;
  localparam int ALIGN_BYTES = 64;
  localparam int HDR_BYTES   = 16;
  localparam int SPLIT_OVER  = 32;
  localparam int SLOTS       = POOL_BYTES / HDR_BYTES;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int AW          = $clog2(POOL_BYTES) + 2;
  localparam int LEN_W       = 16;

  // header states
  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_TBF  = 2'd1;
  localparam logic [1:0] ST_USED = 2'd2;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // answer codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  typedef logic [AW-1:0]    addr_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam addr_t POOL_A   = AW'(POOL_BYTES);
  localparam addr_t HDR_A    = AW'(HDR_BYTES);
  localparam addr_t FREE_MAX = AW'(POOL_BYTES - 32);

  typedef struct packed {
    logic [1:0] st;
    len_t       len;
  } hdr_t;

  typedef struct packed {
    logic  valid;
    logic  status;
    len_t  offset;
  } res_t;

  // header index of a byte offset
  function automatic slot_t slot_of(addr_t off);
    return off[SLOT_W+3:4];
  endfunction

  // unused bytes once bused are taken
  function automatic len_t room_left(addr_t bused);
    addr_t d;
    d = FREE_MAX - bused;
    return (bused >= FREE_MAX) ? '0 : d[LEN_W-1:0];
  endfunction

  // saturating estimate add
  function automatic len_t est_add(len_t a, addr_t b);
    addr_t s;
    s = AW'(a) + b;
    return (s > FREE_MAX) ? FREE_MAX[LEN_W-1:0] : s[LEN_W-1:0];
  endfunction

  // estimate subtract, floored at zero
  function automatic len_t est_sub(len_t a, addr_t b);
    addr_t d;
    d = AW'(a) - b;
    return (b >= AW'(a)) ? '0 : d[LEN_W-1:0];
  endfunction

endpackage

[rtl/first_fit_block_allocator.sv]
// First-fit block allocator over a 64 KiB pool with 16-byte in-band headers.
// After reset the header store is cleared one entry a cycle, all 4096 entries,
// during which no request is taken. A free reads the block's header and marks
// it to-be-freed if it is in use. An allocate walks the headers one by one, and
// when the free estimate is short a recount pass over the headers comes first;
// each header visit goes through the single header memory, whose read data
// arrives in the cycle after the address. One request is worked on at a time;
// the answer sits in an output register so the next request can start.
module first_fit_block_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [15:0]          req_size,
  input  logic [15:0]          region_offset,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 status,
  output logic [15:0]          alloc_offset
);
  import ffba_pkg::*;

  logic  ram_we;
  slot_t ram_waddr;
  hdr_t  ram_wdata;
  logic  ram_re;
  slot_t ram_raddr;
  hdr_t  ram_rdata;
  res_t  res;
  logic  res_ready;

  ffba_hdr_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffba_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .req_size      (req_size),
    .region_offset (region_offset),
    .res           (res),
    .res_ready     (res_ready),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  // output register takes a result when empty or being drained
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      status       <= res.status;
      alloc_offset <= res.offset;
    end
  end

endmodule

[rtl/ffba_hdr_ram.sv]
// header store: one write port, one read port, registered read data
module ffba_hdr_ram (
  input  logic           clk,
  input  logic           we,
  input  ffba_pkg::slot_t waddr,
  input  ffba_pkg::hdr_t  wdata,
  input  logic           re,
  input  ffba_pkg::slot_t raddr,
  output ffba_pkg::hdr_t  rdata
);
  import ffba_pkg::*;

  hdr_t mem [SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ffba_ctrl.sv]
// allocation sequencer: header walk, recount, merge, split and free
module ffba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            req_type,
  input  ffba_pkg::len_t  req_size,
  input  ffba_pkg::len_t  region_offset,
  output ffba_pkg::res_t  res,
  input  logic            res_ready,
  output logic            ram_we,
  output ffba_pkg::slot_t ram_waddr,
  output ffba_pkg::hdr_t  ram_wdata,
  output logic            ram_re,
  output ffba_pkg::slot_t ram_raddr,
  input  ffba_pkg::hdr_t  ram_rdata
);
  import ffba_pkg::*;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CHK     = 4'd2;
  localparam logic [3:0] S_RC_RD   = 4'd3;
  localparam logic [3:0] S_RC_EV   = 4'd4;
  localparam logic [3:0] S_RC_END  = 4'd5;
  localparam logic [3:0] S_W_RD    = 4'd6;
  localparam logic [3:0] S_W_EV    = 4'd7;
  localparam logic [3:0] S_MG_RD   = 4'd8;
  localparam logic [3:0] S_MG_EV   = 4'd9;
  localparam logic [3:0] S_MG_END  = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;
  localparam logic [3:0] S_FIN2    = 4'd12;
  localparam logic [3:0] S_FIN3    = 4'd13;
  localparam logic [3:0] S_FREE_EV = 4'd14;
  localparam logic [3:0] S_RES     = 4'd15;

  localparam addr_t ALIGN_M = AW'(ALIGN_BYTES - 1);

  logic [3:0] state, state_next;
  slot_t      clr_cnt, clr_cnt_next;
  addr_t      h, h_next;
  addr_t      len, len_next;
  addr_t      size, size_next;
  addr_t      ea, ea_next;
  addr_t      bused, bused_next;
  len_t       bf, bf_next;
  len_t       best, best_next;
  len_t       free_bytes, free_bytes_next;
  logic       at_end, at_end_next;
  logic       res_status, res_status_next;
  len_t       res_off, res_off_next;

  addr_t rlen;
  addr_t reg_a;
  addr_t blk_end;
  addr_t rem;
  addr_t len_grow;
  len_t  rb;

  assign in_stall = (state != S_IDLE);
  assign res      = '{valid: (state == S_RES), status: res_status, offset: res_off};

  // sequencer
  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    h_next          = h;
    len_next        = len;
    size_next       = size;
    ea_next         = ea;
    bused_next      = bused;
    bf_next         = bf;
    best_next       = best;
    free_bytes_next = free_bytes;
    at_end_next     = at_end;
    res_status_next = res_status;
    res_off_next    = res_off;
    ram_we          = 1'b0;
    ram_waddr       = slot_of(h);
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = slot_of(h);
    rlen            = AW'(ram_rdata.len);
    reg_a           = AW'(region_offset);
    blk_end         = h + HDR_A + len;
    rem             = len - size;
    len_grow        = len + rlen + HDR_A;
    rb              = '0;

    case (state)
      // sweep the header store to zero after reset
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == slot_t'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end

      // take a request
      S_IDLE: begin
        if (in_valid) begin
          at_end_next = 1'b0;
          h_next      = HDR_A;
          size_next   = (AW'(req_size) + ALIGN_M) & ~ALIGN_M;
          if (req_type == REQ_FREE) begin
            res_off_next = '0;
            if (reg_a[3:0] != 4'd0 || reg_a < AW'(32) || reg_a - HDR_A >= POOL_A) begin
              res_status_next = STAT_FAIL;
              state_next      = S_RES;
            end else begin
              h_next     = reg_a - HDR_A;
              ram_re     = 1'b1;
              ram_raddr  = slot_of(reg_a - HDR_A);
              state_next = S_FREE_EV;
            end
          end else if (req_size == '0) begin
            res_status_next = STAT_FAIL;
            res_off_next    = '0;
            state_next      = S_RES;
          end else begin
            state_next = S_CHK;
          end
        end
      end

      // mark a used block to-be-freed
      S_FREE_EV: begin
        res_off_next = '0;
        if (ram_rdata.st == ST_USED && ram_rdata.len != '0) begin
          ram_we          = 1'b1;
          ram_wdata       = '{st: ST_TBF, len: ram_rdata.len};
          res_status_next = STAT_OK;
        end else begin
          res_status_next = STAT_FAIL;
        end
        state_next = S_RES;
      end

      // decide whether a recount must run first
      S_CHK: begin
        h_next = HDR_A;
        if (AW'(free_bytes) < size + HDR_A) begin
          bused_next = '0;
          best_next  = '0;
          state_next = S_RC_RD;
        end else begin
          bf_next    = free_bytes;
          state_next = S_W_RD;
        end
      end

      // recount pass
      S_RC_RD: begin
        if (h >= POOL_A) begin
          free_bytes_next = room_left(bused);
          state_next      = S_RC_END;
        end else begin
          ram_re     = 1'b1;
          state_next = S_RC_EV;
        end
      end

      S_RC_EV: begin
        rb = room_left(bused);
        if (ram_rdata.len == '0) begin
          free_bytes_next = rb;
          if (rb > best) begin
            best_next = rb;
          end
          state_next = S_RC_END;
        end else if (ram_rdata.st[1]) begin
          bused_next = bused + rlen + HDR_A;
          h_next     = h + rlen + HDR_A;
          state_next = S_RC_RD;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = '{st: ST_FREE, len: ram_rdata.len};
          if (ram_rdata.len > best) begin
            best_next = ram_rdata.len;
          end
          if (h + HDR_A + rlen >= POOL_A) begin
            free_bytes_next = rb;
            state_next      = S_RC_END;
          end else begin
            h_next     = h + rlen + HDR_A;
            state_next = S_RC_RD;
          end
        end
      end

      S_RC_END: begin
        h_next  = HDR_A;
        bf_next = free_bytes;
        if (AW'(best) < size + HDR_A) begin
          res_status_next = STAT_FAIL;
          res_off_next    = '0;
          state_next      = S_RES;
        end else begin
          state_next = S_W_RD;
        end
      end

      // first-fit header walk
      S_W_RD: begin
        if (h >= POOL_A) begin
          free_bytes_next = bf;
          res_status_next = STAT_FAIL;
          res_off_next    = '0;
          state_next      = S_RES;
        end else begin
          ram_re     = 1'b1;
          state_next = S_W_EV;
        end
      end

      S_W_EV: begin
        if (ram_rdata.st[1]) begin
          if (ram_rdata.len == '0) begin
            free_bytes_next = bf;
            res_status_next = STAT_FAIL;
            res_off_next    = '0;
            state_next      = S_RES;
          end else begin
            h_next     = h + rlen + HDR_A;
            state_next = S_W_RD;
          end
        end else begin
          if (ram_rdata.st == ST_TBF) begin
            bf_next   = est_add(bf, rlen + HDR_A);
            ram_we    = 1'b1;
            ram_wdata = '{st: ST_FREE, len: ram_rdata.len};
          end
          if (ram_rdata.len == '0) begin
            if (h + HDR_A + size > POOL_A) begin
              free_bytes_next = (ram_rdata.st == ST_TBF) ? est_add(bf, rlen + HDR_A) : bf;
              res_status_next = STAT_FAIL;
              res_off_next    = '0;
              state_next      = S_RES;
            end else begin
              len_next    = size;
              at_end_next = 1'b1;
              state_next  = S_FIN;
            end
          end else if (rlen < size) begin
            len_next   = rlen;
            state_next = S_MG_RD;
          end else begin
            len_next   = rlen;
            state_next = S_FIN;
          end
        end
      end

      // merge following free or to-be-freed blocks
      S_MG_RD: begin
        ea_next = blk_end;
        if (blk_end >= POOL_A) begin
          state_next = S_MG_END;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = slot_of(blk_end);
          state_next = S_MG_EV;
        end
      end

      S_MG_EV: begin
        if (ram_rdata.len == '0) begin
          if (h + HDR_A + size <= POOL_A) begin
            len_next    = size;
            at_end_next = 1'b1;
          end else begin
            len_next = len + (POOL_A - ea);
          end
          state_next = S_MG_END;
        end else if (ram_rdata.st[1]) begin
          state_next = S_MG_END;
        end else begin
          if (ram_rdata.st == ST_TBF) begin
            bf_next = est_add(bf, rlen + HDR_A);
          end
          len_next  = len_grow;
          ram_we    = 1'b1;
          ram_waddr = slot_of(ea);
          ram_wdata = '0;
          if (h + HDR_A + len_grow >= POOL_A) begin
            state_next = S_MG_END;
          end else begin
            state_next = S_MG_RD;
          end
        end
      end

      S_MG_END: begin
        if (len >= size) begin
          state_next = S_FIN;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = '{st: ST_FREE, len: len[LEN_W-1:0]};
          if (blk_end >= POOL_A) begin
            free_bytes_next = bf;
            res_status_next = STAT_FAIL;
            res_off_next    = '0;
            state_next      = S_RES;
          end else begin
            h_next     = blk_end;
            state_next = S_W_RD;
          end
        end
      end

      // split off a remainder
      S_FIN: begin
        if (rem > AW'(SPLIT_OVER)) begin
          ram_we    = 1'b1;
          ram_waddr = slot_of(h + HDR_A + size);
          ram_wdata = '{st: ST_FREE, len: len_t'(rem - HDR_A)};
          len_next  = size;
        end
        state_next = S_FIN2;
      end

      // mark the block used and answer
      S_FIN2: begin
        ram_we          = 1'b1;
        ram_wdata       = '{st: ST_USED, len: len[LEN_W-1:0]};
        free_bytes_next = est_sub(bf, HDR_A + len);
        res_status_next = STAT_OK;
        res_off_next    = len_t'(h + HDR_A);
        if (at_end && blk_end < POOL_A) begin
          state_next = S_FIN3;
        end else begin
          state_next = S_RES;
        end
      end

      // new end marker after a block taken at the end
      S_FIN3: begin
        ram_we     = 1'b1;
        ram_waddr  = slot_of(blk_end);
        ram_wdata  = '0;
        state_next = S_RES;
      end

      // hand the answer to the output register
      S_RES: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      free_bytes <= FREE_MAX[LEN_W-1:0];
    end else begin
      state      <= state_next;
      clr_cnt    <= clr_cnt_next;
      free_bytes <= free_bytes_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    h          <= h_next;
    len        <= len_next;
    size       <= size_next;
    ea         <= ea_next;
    bused      <= bused_next;
    bf         <= bf_next;
    best       <= best_next;
    at_end     <= at_end_next;
    res_status <= res_status_next;
    res_off    <= res_off_next;
  end

endmodule

[rtl/ffba_checker.sv]
// port-level checks of the allocator and their bind
`include "first_fit_block_allocator_defines.svh"

module ffba_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        status,
  input logic [15:0] alloc_offset
);

  // a failure never carries an offset
  `FFBA_IMPLIES(a_fail_no_off, out_valid && status, alloc_offset == 16'd0, "failure with offset")

  // a granted offset is granule aligned and past the first header
  `FFBA_IMPLIES(a_off_shape, out_valid && alloc_offset != 16'd0, alloc_offset[3:0] == 4'd0 && alloc_offset >= 16'd32 && !status, "bad granted offset")

  // one request at a time: a transfer in closes the input next cycle
  `FFBA_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "input open after transfer")

  // a stalled result holds
  `FFBA_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(alloc_offset), "stalled result changed")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

[sim/tb_top.sv]
// testbench for the first-fit block allocator: self-checking, random and directed
`timescale 1ns / 1ps

module tb_top;
  import ffba_pkg::*;

  localparam int unsigned POOL = POOL_BYTES;
  localparam int unsigned HDR = HDR_BYTES;
  localparam int unsigned EST_MAX = POOL_BYTES - 32;

  typedef struct {
    logic        status;
    logic [15:0] offset;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [15:0] req_size;
  logic [15:0] region_offset;
  logic        out_valid;
  logic        out_stall;
  logic        status;
  logic [15:0] alloc_offset;

  // shadow copy of the pool headers and the free estimate
  logic [1:0]  shadow_st [SLOTS];
  int unsigned shadow_len [SLOTS];
  int unsigned free_est;

  answer_t     pending_answers[$];
  logic [15:0] live_blocks[$];
  int          errors;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          hold_cycles;

  first_fit_block_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .req_size     (req_size),
    .region_offset(region_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .alloc_offset (alloc_offset)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic int unsigned slot_idx(int unsigned off);
    return (off / HDR) % SLOTS;
  endfunction

  function automatic int unsigned left_after(int unsigned bused);
    return (bused >= EST_MAX) ? 0 : EST_MAX - bused;
  endfunction

  function automatic int unsigned sat_add(int unsigned a, int unsigned b);
    return (a + b > EST_MAX) ? EST_MAX : a + b;
  endfunction

  function automatic int unsigned floor_sub(int unsigned a, int unsigned b);
    return (b >= a) ? 0 : a - b;
  endfunction

  // recount pass: to-be-freed become free, returns the largest free run
  function automatic int unsigned recount_free();
    int unsigned h, bused, best, bf, n;
    h = HDR;
    bused = 0;
    best = 0;
    forever begin
      if (h >= POOL) begin
        bf = left_after(bused);
        break;
      end
      n = slot_idx(h);
      if (shadow_len[n] == 0) begin
        bf = left_after(bused);
        if (bf > best) best = bf;
        break;
      end
      if (shadow_st[n] >= ST_USED) begin
        bused += shadow_len[n] + HDR;
        h += shadow_len[n] + HDR;
        continue;
      end
      shadow_st[n] = ST_FREE;
      if (shadow_len[n] > best) best = shadow_len[n];
      if (h + HDR + shadow_len[n] >= POOL) begin
        bf = left_after(bused);
        break;
      end
      h += shadow_len[n] + HDR;
    end
    free_est = bf;
    return best;
  endfunction

  // grow a too-short block over the free or to-be-freed blocks after it
  function automatic int unsigned grow_block(int unsigned h, int unsigned size,
                                             int unsigned len, inout int unsigned bf,
                                             inout bit at_end);
    int unsigned e, n;
    forever begin
      e = h + HDR + len;
      if (e >= POOL) break;
      n = slot_idx(e);
      if (shadow_len[n] == 0) begin
        if (h + HDR + size <= POOL) begin
          len = size;
          at_end = 1'b1;
        end else begin
          len += POOL - e;
        end
        break;
      end
      if (shadow_st[n] >= ST_USED) break;
      if (shadow_st[n] == ST_TBF) bf = sat_add(bf, shadow_len[n] + HDR);
      len += shadow_len[n] + HDR;
      shadow_st[n] = ST_FREE;
      shadow_len[n] = 0;
      if (h + HDR + len >= POOL) break;
    end
    return len;
  endfunction

  // first-fit walk, returns the data offset or 0 on failure
  function automatic int unsigned predict_alloc(int unsigned req);
    int unsigned size, bf, h, len, rem, n;
    bit at_end;
    at_end = 1'b0;
    if (req == 0) return 0;
    size = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    if (free_est < size + HDR) begin
      if (recount_free() < size + HDR) return 0;
    end
    bf = free_est;
    h = HDR;
    forever begin
      if (h >= POOL) begin
        free_est = bf;
        return 0;
      end
      n = slot_idx(h);
      if (shadow_st[n] >= ST_USED) begin
        if (shadow_len[n] == 0) begin
          free_est = bf;
          return 0;
        end
        h += shadow_len[n] + HDR;
        continue;
      end
      if (shadow_st[n] == ST_TBF) begin
        bf = sat_add(bf, shadow_len[n] + HDR);
        shadow_st[n] = ST_FREE;
      end
      len = shadow_len[n];
      if (len == 0) begin
        if (h + HDR + size > POOL) begin
          free_est = bf;
          return 0;
        end
        len = size;
        at_end = 1'b1;
        break;
      end
      if (len < size) begin
        len = grow_block(h, size, len, bf, at_end);
        if (len >= size) break;
        shadow_len[n] = len;
        if (h + HDR + len >= POOL) begin
          free_est = bf;
          return 0;
        end
        h += len + HDR;
        continue;
      end
      break;
    end
    // split off a remainder worth keeping
    rem = len - size;
    if (rem > SPLIT_OVER) begin
      shadow_st[slot_idx(h + HDR + size)] = ST_FREE;
      shadow_len[slot_idx(h + HDR + size)] = rem - HDR;
      len = size;
    end
    shadow_st[slot_idx(h)] = ST_USED;
    shadow_len[slot_idx(h)] = len;
    if (at_end && h + HDR + len < POOL) begin
      shadow_st[slot_idx(h + HDR + len)] = ST_FREE;
      shadow_len[slot_idx(h + HDR + len)] = 0;
    end
    free_est = floor_sub(bf, HDR + len);
    return h + HDR;
  endfunction

  // free only marks a used block to-be-freed
  function automatic logic predict_free(int unsigned r);
    int unsigned n;
    if ((r % HDR) != 0 || r < 32 || r - HDR >= POOL) return STAT_FAIL;
    n = slot_idx(r - HDR);
    if (shadow_st[n] != ST_USED || shadow_len[n] == 0) return STAT_FAIL;
    shadow_st[n] = ST_TBF;
    return STAT_OK;
  endfunction

  // one request transfer, then its expected answer
  task automatic send_req(logic kind, logic [15:0] size, logic [15:0] offset);
    bit ok;
    answer_t a;
    int unsigned got;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= kind;
    req_size      <= size;
    region_offset <= offset;
    forever begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
      if (ok) break;
    end
    if (kind == REQ_ALLOC) begin
      got = predict_alloc(size);
      a.status = (got != 0) ? STAT_OK : STAT_FAIL;
      a.offset = got[15:0];
      if (got != 0) live_blocks.push_back(got[15:0]);
    end else begin
      a.status = predict_free(offset);
      a.offset = '0;
    end
    pending_answers.push_back(a);
  endtask

  task automatic alloc_req(logic [15:0] size);
    send_req(REQ_ALLOC, size, 16'($urandom));
  endtask

  task automatic free_req(logic [15:0] offset);
    send_req(REQ_FREE, 16'($urandom), offset);
  endtask

  // free a live block picked at random
  task automatic free_live();
    int k;
    logic [15:0] off;
    if (live_blocks.size() == 0) begin
      alloc_req(16'($urandom_range(1, 1024)));
    end else begin
      k = $urandom_range(live_blocks.size() - 1);
      off = live_blocks[k];
      live_blocks.delete(k);
      free_req(off);
    end
  endtask

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // check each answer transfer against the oldest expectation
  always @(negedge clk) begin
    answer_t a;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer status=%0d offset=%0d", $time, status, alloc_offset);
        errors++;
      end else begin
        a = pending_answers.pop_front();
        if (status !== a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, a.status, status);
          errors++;
        end
        if (alloc_offset !== a.offset) begin
          $display("%0t: alloc_offset expected %0d actual %0d", $time, a.offset,
                   alloc_offset);
          errors++;
        end
      end
    end
  end

  // edge cases of sizes and offsets
  task automatic test_directed();
    logic [15:0] a0, a1;
    alloc_req(16'd0);
    alloc_req(16'd1);
    alloc_req(16'd64);
    alloc_req(16'd65);
    alloc_req(16'd200);
    a0 = live_blocks[0];
    a1 = live_blocks[1];
    free_req(a1);
    free_req(a1);
    free_req(16'd0);
    free_req(16'd16);
    free_req(16'd33);
    free_req(16'hFFFF);
    free_req(16'd65520);
    alloc_req(16'd64);
    alloc_req(16'hFFFF);
    while (live_blocks.size() > 0) free_live();
    alloc_req(16'd65000);
    alloc_req(16'd64);
    free_live();
    alloc_req(16'd65472);
    alloc_req(16'd1);
    free_live();
    free_req(a0);
  endtask

  // random mix of allocates and frees
  task automatic test_random(int items, int idle_pct, int stall_pct);
    int r;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (items) begin
      r = $urandom_range(99);
      if (r < 50) alloc_req(16'($urandom_range(1, 2048)));
      else if (r < 55) alloc_req(16'($urandom));
      else if (r < 92) free_live();
      else free_req(16'($urandom));
    end
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_cycles = 3000;
    repeat (12) alloc_req(16'($urandom_range(1, 512)));
    repeat (6) free_live();
  endtask

  initial begin
    errors = 0;
    hold_cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    in_valid = 1'b0;
    req_type = REQ_ALLOC;
    req_size = '0;
    region_offset = '0;
    out_stall = 1'b0;
    free_est = EST_MAX;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_st[i] = ST_FREE;
      shadow_len[i] = 0;
    end
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400, 0, 0);
    test_backpressure();
    test_random(400, 83, 0);
    test_random(400, 0, 83);
    test_random(400, 12, 12);
    in_valid <= 1'b0;
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_hdr_ram.sv
rtl/ffba_ctrl.sv
rtl/first_fit_block_allocator.sv
rtl/ffba_checker.sv
sim/tb_top.sv
